// ===== hdl/das_pkg.sv =====
package das_pkg;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CHECK = 2'd1;
    localparam logic [1:0] PH_SUB   = 2'd2;
    localparam logic [1:0] PH_FORCE = 2'd3;

    // Reference kinds
    localparam logic [1:0] ZM_DEPTH = 2'd1;
    localparam logic [1:0] ZM_ALT   = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOLO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FRAC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PCT   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_DEPTH_THR = 16'd600;
    localparam logic [14:0] RST_RPM_FLOOR = 15'd200;
    localparam logic [15:0] RST_SOLO      = 16'd8;
    localparam logic [15:0] RST_STEP      = 16'd2;
    localparam logic [16:0] RST_STEP_FRAC = 17'd6554;
    localparam logic [9:0]  RST_MAX_PCT   = 10'd50;

    // Arithmetic constants
    localparam logic [23:0] SPEED_MAX  = 24'hFFFFFF;
    localparam logic [6:0]  INC_MAX    = 7'd127;
    localparam logic [40:0] ROUND_HALF = 41'd32768;

    localparam int TIMER_WIDTH_DEF = 16;

    typedef struct packed {
        logic [15:0] depth_thr;
        logic [14:0] rpm_floor;
        logic [15:0] solo_ticks;
        logic [15:0] step_ticks;
        logic [16:0] step_frac;
        logic [9:0]  max_pct;
    } t_cfg;

    typedef struct packed {
        logic               enabled;
        logic               brake;
        logic signed [23:0] depth_mm;
        logic signed [23:0] altitude_mm;
        logic signed [15:0] motor_rpm;
        logic signed [23:0] desired_speed;
        logic signed [23:0] z_ref_mm;
        logic [1:0]         z_mode;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  phase;
        logic [23:0] speed_cmd;
        logic        speed_cmd_valid;
        logic        restore_refs;
        logic        failed;
    } t_out_item;

    // Supervisor state apart from the tick counters
    typedef struct packed {
        logic [1:0]  phase;
        logic        data_seen;
        logic        last_attempt;
        logic        fail_latch;
        logic        enabled_prev;
        logic [6:0]  increase_count;
        logic [23:0] speed_increment;
        logic [23:0] forced_speed;
    } t_ctl;

endpackage

// ===== hdl/das_if.sv =====
// Tick input channel
interface das_in_if;
    import das_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Result channel
interface das_out_if;
    import das_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Configuration write channel
interface das_cfg_if;
    import das_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dive_assist_supervisor.sv =====
// Dive assist supervisor: each tick item on i_in yields exactly one result item on
// o_out. A tick is captured in an input register, the whole phase-machine update
// (counters, hysteresis compares, one 24x17 speed-step multiply) runs in a single
// combinational pass, and the result lands in an output register, so one item is
// taken every cycle when the output side does not stall; its result passes the input
// register and then the output register before it is presented on o_out. Throughput
// is set by the state update loop through the supervisor state registers. Configuration
// writes on i_cfg are always accepted and take effect on the next tick.
module dive_assist_supervisor #(
    parameter int TIMER_WIDTH = das_pkg::TIMER_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    das_in_if.sink    i_in,
    das_out_if.source o_out,
    das_cfg_if.sink   i_cfg
);
    import das_pkg::*;

    t_cfg cfg;

    das_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Pipeline control
    logic advance, process;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign advance     = !r_out_valid || o_out.ready;
    assign process     = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    // Supervisor state
    t_ctl                   r_ctl, n_ctl;
    logic [TIMER_WIDTH-1:0] r_solo, n_solo, r_step, n_step;
    t_out_item              n_out_item;

    das_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
        .i_cfg  (cfg),
        .i_item (r_in_item),
        .i_ctl  (r_ctl),
        .i_solo (r_solo),
        .i_step (r_step),
        .o_ctl  (n_ctl),
        .o_solo (n_solo),
        .o_step (n_step),
        .o_res  (n_out_item)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.item;
        end
    end

    // State and output register advance together with each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_solo      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_ctl       <= n_ctl;
            r_solo      <= n_solo;
            r_step      <= n_step;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

// ===== hdl/das_cfg.sv =====
module das_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    das_cfg_if.sink        i_cfg,
    output das_pkg::t_cfg  o_cfg
);
    import das_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_thr  <= RST_DEPTH_THR;
            r_cfg.rpm_floor  <= RST_RPM_FLOOR;
            r_cfg.solo_ticks <= RST_SOLO;
            r_cfg.step_ticks <= RST_STEP;
            r_cfg.step_frac  <= RST_STEP_FRAC;
            r_cfg.max_pct    <= RST_MAX_PCT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEPTH_THR: r_cfg.depth_thr  <= i_cfg.data[15:0];
                REG_RPM_FLOOR: r_cfg.rpm_floor  <= i_cfg.data[14:0];
                REG_SOLO:      r_cfg.solo_ticks <= i_cfg.data[15:0];
                REG_STEP:      r_cfg.step_ticks <= i_cfg.data[15:0];
                REG_STEP_FRAC: r_cfg.step_frac  <= i_cfg.data[16:0];
                REG_MAX_PCT:   r_cfg.max_pct    <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/das_step.sv =====
module das_step #(
    parameter int TIMER_WIDTH = das_pkg::TIMER_WIDTH_DEF
) (
    input  das_pkg::t_cfg         i_cfg,
    input  das_pkg::t_in_item     i_item,
    input  das_pkg::t_ctl         i_ctl,
    input  logic [TIMER_WIDTH-1:0] i_solo,
    input  logic [TIMER_WIDTH-1:0] i_step,
    output das_pkg::t_ctl         o_ctl,
    output logic [TIMER_WIDTH-1:0] o_solo,
    output logic [TIMER_WIDTH-1:0] o_step,
    output das_pkg::t_out_item    o_res
);
    import das_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
    localparam logic [TIMER_WIDTH-1:0] TONE = TIMER_WIDTH'(1);

    function automatic t_ctl ctl_clear(t_ctl c);
        t_ctl r;
        r                 = c;
        r.phase           = PH_IDLE;
        r.data_seen       = 1'b0;
        r.last_attempt    = 1'b0;
        r.increase_count  = '0;
        r.speed_increment = '0;
        return r;
    endfunction

    // Widened signed operands for the depth and rpm compares
    logic signed [25:0] thr_w, depth_w, alt_w, zref_w, depth2_w, alt_thr_w;
    logic signed [16:0] rpm_w, tol_w;
    logic               dspeed_pos, dspeed_zero, hz, data_ok;

    assign thr_w     = $signed({10'b0, i_cfg.depth_thr});
    assign depth_w   = $signed({{2{i_item.depth_mm[23]}}, i_item.depth_mm});
    assign alt_w     = $signed({{2{i_item.altitude_mm[23]}}, i_item.altitude_mm});
    assign zref_w    = $signed({{2{i_item.z_ref_mm[23]}}, i_item.z_ref_mm});
    assign depth2_w  = $signed({depth_w[24:0], 1'b0});
    assign alt_thr_w = alt_w - thr_w;
    assign rpm_w     = $signed({i_item.motor_rpm[15], i_item.motor_rpm});
    assign tol_w     = $signed({2'b0, i_cfg.rpm_floor});

    assign dspeed_zero = (i_item.desired_speed == '0);
    assign dspeed_pos  = !i_item.desired_speed[23] && !dspeed_zero;

    // Valid vertical reference for the current mode
    always_comb begin
        case (i_item.z_mode)
            ZM_DEPTH: hz = (zref_w > thr_w);
            ZM_ALT:   hz = (depth_w > thr_w) ? (zref_w < alt_thr_w) : 1'b1;
            default:  hz = 1'b0;
        endcase
    end

    always_comb begin
        case (i_item.z_mode)
            ZM_DEPTH: data_ok = !i_item.depth_mm[23] && !i_item.z_ref_mm[23];
            ZM_ALT:   data_ok = !i_item.altitude_mm[23] && !i_item.z_ref_mm[23];
            default:  data_ok = 1'b0;
        endcase
    end

    // Speed step: base, rounded increment, next forced speed
    logic [23:0] base, inc_sat, cur_fs, cur_inc, sum_sat;
    logic [40:0] prod_rnd;
    logic [24:0] sum;
    logic [6:0]  cnt_n;
    logic [10:0] cnt_x10;
    logic        first, over;

    assign base     = i_item.desired_speed[23] ? '0 : i_item.desired_speed;
    assign prod_rnd = 41'(base) * 41'(i_cfg.step_frac) + ROUND_HALF;
    assign inc_sat  = prod_rnd[40] ? SPEED_MAX : prod_rnd[39:16];
    assign first    = (i_ctl.increase_count == '0);
    assign cur_fs   = first ? base : i_ctl.forced_speed;
    assign cur_inc  = first ? inc_sat : i_ctl.speed_increment;
    assign sum      = {1'b0, cur_fs} + {1'b0, cur_inc};
    assign sum_sat  = sum[24] ? SPEED_MAX : sum[23:0];
    assign cnt_n    = (i_ctl.increase_count < INC_MAX) ? i_ctl.increase_count + 7'd1
                                                       : i_ctl.increase_count;
    assign cnt_x10  = ({4'b0, cnt_n} << 3) + ({4'b0, cnt_n} << 1);
    assign over     = (cnt_x10 > {1'b0, i_cfg.max_pct});

    // Tick update, in the order of the supervision rules
    t_ctl                   c;
    logic [TIMER_WIDTH-1:0] solo, stp;
    logic                   vld, rst_o;
    logic [23:0]            spd;
    logic                   en, brk;

    always_comb begin
        c     = i_ctl;
        solo  = i_solo;
        stp   = i_step;
        vld   = 1'b0;
        rst_o = 1'b0;
        spd   = '0;
        en    = i_item.enabled;
        brk   = i_item.brake;

        if (en) begin
            if (solo != TMAX) solo = solo + TONE;
            if (stp != TMAX)  stp  = stp + TONE;
        end

        // enable edge
        if (en != c.enabled_prev) begin
            c    = ctl_clear(c);
            solo = '0;
            stp  = '0;
            if (en) c.fail_latch = 1'b0;
        end
        c.enabled_prev = en;

        // brake
        if (en && brk) begin
            if (c.phase == PH_FORCE) rst_o = 1'b1;
            c.last_attempt = 1'b0;
            solo           = '0;
            stp            = '0;
            c.phase        = PH_IDLE;
        end

        // data gate
        if (en && !c.data_seen && data_ok && !i_item.desired_speed[23]
            && !i_item.motor_rpm[15]) begin
            c.data_seen = 1'b1;
        end

        if (en && c.data_seen && !c.fail_latch && !brk) begin
            case (c.phase)
                PH_IDLE: begin
                    if (depth_w < thr_w && zref_w > thr_w && dspeed_pos
                        && rpm_w > tol_w) begin
                        c.phase = PH_CHECK;
                        solo    = '0;
                    end
                end
                PH_CHECK: begin
                    if (!hz || dspeed_zero) begin
                        solo    = '0;
                        c.phase = PH_IDLE;
                    end
                    if (depth_w > thr_w) c.phase = PH_SUB;
                    if (CMP_W'(solo) >= CMP_W'(i_cfg.solo_ticks)) begin
                        stp     = '0;
                        c.phase = PH_FORCE;
                        c.forced_speed    = cur_fs;
                        c.speed_increment = cur_inc;
                        c.increase_count  = cnt_n;
                        if (!over) begin
                            c.forced_speed = sum_sat;
                            vld            = 1'b1;
                            spd            = sum_sat;
                            stp            = '0;
                        end
                    end
                end
                PH_SUB: begin
                    if (!hz) c.phase = PH_IDLE;
                    if (depth2_w < thr_w) begin
                        solo    = '0;
                        c.phase = PH_CHECK;
                    end
                end
                default: begin
                    if (!hz || dspeed_zero) begin
                        c.phase          = PH_IDLE;
                        c.increase_count = '0;
                        c.last_attempt   = 1'b0;
                    end else if (depth_w > thr_w) begin
                        c.phase          = PH_SUB;
                        c.increase_count = '0;
                        c.last_attempt   = 1'b0;
                        rst_o            = 1'b1;
                    end else if (CMP_W'(stp) >= CMP_W'(i_cfg.step_ticks)) begin
                        c.forced_speed    = cur_fs;
                        c.speed_increment = cur_inc;
                        c.increase_count  = cnt_n;
                        if (!over) begin
                            c.forced_speed = sum_sat;
                            vld            = 1'b1;
                            spd            = sum_sat;
                            stp            = '0;
                        end else if (!c.last_attempt) begin
                            solo           = '0;
                            c.last_attempt = 1'b1;
                        end else if (CMP_W'(solo) >= CMP_W'(i_cfg.solo_ticks)) begin
                            // out of tries: latch failure and hand references back
                            c.fail_latch = 1'b1;
                            rst_o        = 1'b1;
                            c            = ctl_clear(c);
                            solo         = '0;
                            stp          = '0;
                        end
                    end
                end
            endcase
        end

        o_ctl                 = c;
        o_solo                = solo;
        o_step                = stp;
        o_res.phase           = c.phase;
        o_res.speed_cmd       = vld ? spd : '0;
        o_res.speed_cmd_valid = vld;
        o_res.restore_refs    = rst_o;
        o_res.failed          = c.fail_latch;
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    import das_pkg::*;

    // Reference kinds the package leaves unnamed
    localparam logic [1:0] ZM_NONE = 2'd0;
    localparam logic [1:0] ZM_BAD  = 2'd3;

    localparam int     TMR_MAX     = (1 << TIMER_WIDTH_DEF) - 1;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     NUM_PHASES  = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    das_in_if  in_if();
    das_out_if out_if();
    das_cfg_if cfg_if();

    dive_assist_supervisor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Ticks waiting to be sent, results still owed by the block
    t_in_item  pending_ticks[$];
    t_out_item due_results[$];

    int gap_odds;
    int stall_odds;
    int gap_left;
    int stall_left;
    int mismatches;
    int cycle_cnt;

    // Supervisor model state
    t_cfg        cfg_model;
    logic [1:0]  sv_phase;
    bit          sv_seen;
    bit          sv_last_try;
    bit          sv_failed;
    bit          sv_en_prev;
    int          sv_raises;
    longint      sv_step_inc;
    longint      sv_forced;
    int          sv_solo;
    int          sv_step;

    // Per-tick outputs of the model
    bit          cmd_issued;
    bit          restore_now;
    logic [23:0] cmd_speed;

    function automatic void clear_machine();
        sv_phase    = PH_IDLE;
        sv_seen     = 1'b0;
        sv_last_try = 1'b0;
        sv_raises   = 0;
        sv_step_inc = 0;
        sv_solo     = 0;
        sv_step     = 0;
    endfunction

    // One speed increase; returns 0 once the increase limit is passed
    function automatic bit step_up_speed(longint dsp);
        longint base;
        longint inc;
        longint sum;
        if (sv_raises == 0) begin
            base = (dsp < 0) ? 0 : dsp;
            inc = (base * longint'(cfg_model.step_frac) + 32768) >> 16;
            sv_forced = base;
            sv_step_inc = (inc > longint'(SPEED_MAX)) ? longint'(SPEED_MAX) : inc;
        end
        if (sv_raises < int'(INC_MAX))
            sv_raises++;
        if (sv_raises * 10 > int'(cfg_model.max_pct))
            return 1'b0;
        sum = sv_forced + sv_step_inc;
        sv_forced = (sum > longint'(SPEED_MAX)) ? longint'(SPEED_MAX) : sum;
        cmd_issued = 1'b1;
        cmd_speed = sv_forced[23:0];
        sv_step = 0;
        return 1'b1;
    endfunction

    // Expected result of one supervision tick
    function automatic t_out_item supervise_tick(t_in_item t);
        longint    depth;
        longint    alt;
        longint    rpm;
        longint    dsp;
        longint    zref;
        longint    thr;
        bit        hz;
        bit        data_ok;
        t_out_item r;
        depth = $signed(t.depth_mm);
        alt   = $signed(t.altitude_mm);
        rpm   = $signed(t.motor_rpm);
        dsp   = $signed(t.desired_speed);
        zref  = $signed(t.z_ref_mm);
        thr   = longint'(cfg_model.depth_thr);
        cmd_issued  = 1'b0;
        restore_now = 1'b0;
        cmd_speed   = '0;

        if (t.enabled) begin
            if (sv_solo < TMR_MAX) sv_solo++;
            if (sv_step < TMR_MAX) sv_step++;
        end
        // any enable edge restarts the machine, a rise also clears the failure
        if (t.enabled != sv_en_prev) begin
            clear_machine();
            if (t.enabled) sv_failed = 1'b0;
        end
        sv_en_prev = t.enabled;

        if (t.enabled && t.brake) begin
            if (sv_phase == PH_FORCE) restore_now = 1'b1;
            sv_last_try = 1'b0;
            sv_solo = 0;
            sv_step = 0;
            sv_phase = PH_IDLE;
        end

        // wait for a complete set of measurements once
        if (t.enabled && !sv_seen) begin
            case (t.z_mode)
                ZM_DEPTH: data_ok = (depth >= 0) && (zref >= 0);
                ZM_ALT:   data_ok = (alt >= 0) && (zref >= 0);
                default:  data_ok = 1'b0;
            endcase
            if (data_ok && dsp >= 0 && rpm >= 0) sv_seen = 1'b1;
        end

        if (t.enabled && sv_seen && !sv_failed && !t.brake) begin
            case (t.z_mode)
                ZM_DEPTH: hz = zref > thr;
                ZM_ALT:   hz = (depth > thr) ? (zref < alt - thr) : 1'b1;
                default:  hz = 1'b0;
            endcase
            case (sv_phase)
                PH_IDLE: begin
                    if (depth < thr && zref > thr && dsp > 0 &&
                        rpm > longint'(cfg_model.rpm_floor)) begin
                        sv_phase = PH_CHECK;
                        sv_solo = 0;
                    end
                end
                PH_CHECK: begin
                    if (!hz || dsp == 0) begin
                        sv_solo = 0;
                        sv_phase = PH_IDLE;
                    end
                    if (depth > thr) sv_phase = PH_SUB;
                    if (sv_solo >= int'(cfg_model.solo_ticks)) begin
                        sv_step = 0;
                        sv_phase = PH_FORCE;
                        void'(step_up_speed(dsp));
                    end
                end
                PH_SUB: begin
                    if (!hz) sv_phase = PH_IDLE;
                    if (2 * depth < thr) begin
                        sv_solo = 0;
                        sv_phase = PH_CHECK;
                    end
                end
                default: begin
                    if (!hz || dsp == 0) begin
                        sv_phase = PH_IDLE;
                        sv_raises = 0;
                        sv_last_try = 1'b0;
                    end else if (depth > thr) begin
                        sv_phase = PH_SUB;
                        sv_raises = 0;
                        sv_last_try = 1'b0;
                        restore_now = 1'b1;
                    end else if (sv_step >= int'(cfg_model.step_ticks)) begin
                        if (!step_up_speed(dsp)) begin
                            // limit reached: one more wait, then give up
                            if (!sv_last_try) begin
                                sv_solo = 0;
                                sv_last_try = 1'b1;
                            end else if (sv_solo >= int'(cfg_model.solo_ticks)) begin
                                sv_failed = 1'b1;
                                restore_now = 1'b1;
                                clear_machine();
                            end
                        end
                    end
                end
            endcase
        end

        r.phase           = sv_phase;
        r.speed_cmd       = cmd_issued ? cmd_speed : '0;
        r.speed_cmd_valid = cmd_issued;
        r.restore_refs    = restore_now;
        r.failed          = sv_failed;
        return r;
    endfunction

    function automatic void add_tick(bit en, bit brk, int depth, int alt, int rpm,
                                     int dsp, int zref, logic [1:0] mode);
        t_in_item it;
        it.enabled       = en;
        it.brake         = brk;
        it.depth_mm      = 24'(depth);
        it.altitude_mm   = 24'(alt);
        it.motor_rpm     = 16'(rpm);
        it.desired_speed = 24'(dsp);
        it.z_ref_mm      = 24'(zref);
        it.z_mode        = mode;
        pending_ticks.push_back(it);
    endfunction

    // One stretch of ticks: mostly a dive attempt with random content, sometimes noise
    task automatic queue_segment(output int len);
        int thr;
        int tol;
        int zref;
        int dsp;
        int depth;
        int alt;
        int rpm;
        int dd;
        int z;
        int kind;
        int deep_odds;
        int upset_odds;
        int i;
        logic [1:0] mode;
        logic [127:0] noise;
        thr = int'(cfg_model.depth_thr);
        tol = int'(cfg_model.rpm_floor);
        kind = $urandom_range(0, 9);
        len = $urandom_range(4, 80);
        // sinking stretches reach depth often, stuck ones almost never
        deep_odds = (kind < 4) ? 12 : 300;
        upset_odds = (kind < 4) ? 60 : 400;
        mode = ($urandom_range(0, 1) != 0) ? ZM_DEPTH : ZM_ALT;
        zref = thr + int'($urandom_range(1, 200000));
        dsp = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 255))
                                          : int'($urandom_range(1, 24'h7FFFFF));
        for (i = 0; i < len; i++) begin
            if (kind == 9) begin
                noise = {$urandom, $urandom, $urandom, $urandom};
                pending_ticks.push_back(t_in_item'(noise[$bits(t_in_item)-1:0]));
            end else begin
                if ($urandom_range(1, deep_odds) == 1)
                    depth = thr + int'($urandom_range(1, 5000));
                else if (thr == 0 || $urandom_range(0, 30) == 0)
                    depth = -int'($urandom_range(1, 1000));
                else
                    depth = $urandom_range(0, thr - 1);
                if (mode == ZM_ALT && $urandom_range(0, 20) != 0)
                    alt = zref + thr + int'($urandom_range(1, 100000));
                else
                    alt = $urandom_range(0, 24'h7FFFFF);
                if (tol == 32767 || $urandom_range(0, 30) == 0)
                    rpm = int'($urandom_range(0, 65535)) - 32768;
                else
                    rpm = tol + int'($urandom_range(1, 32767 - tol));
                dd = dsp;
                if ($urandom_range(0, 40) == 0)
                    dd = 0;
                else if ($urandom_range(0, 40) == 0)
                    dd = -int'($urandom_range(1, 8388608));
                z = ($urandom_range(0, 40) == 0) ? int'($urandom_range(0, 24'hFFFFFF)) - 8388608
                                                 : zref;
                add_tick($urandom_range(1, upset_odds) != 1, $urandom_range(1, upset_odds) == 1,
                         depth, alt, rpm, dd, z,
                         ($urandom_range(0, 40) == 0) ? 2'($urandom) : mode);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_DEPTH_THR: cfg_model.depth_thr  = val[15:0];
            REG_RPM_FLOOR: cfg_model.rpm_floor  = val[14:0];
            REG_SOLO:      cfg_model.solo_ticks = val[15:0];
            REG_STEP:      cfg_model.step_ticks = val[15:0];
            REG_STEP_FRAC: cfg_model.step_frac  = val[16:0];
            REG_MAX_PCT:   cfg_model.max_pct    = val[9:0];
            default: ;
        endcase
    endtask

    // Settings: min thresholds, fast forcing; max thresholds and timers; zero timers; random
    task automatic load_setting(int sel);
        int unsigned thr;
        int unsigned tol;
        int unsigned solo;
        int unsigned step;
        int unsigned frac;
        int unsigned pct;
        thr  = $urandom_range(0, 3000);
        tol  = $urandom_range(0, 3000);
        solo = $urandom_range(1, 12);
        step = $urandom_range(1, 4);
        frac = $urandom_range(0, 65536);
        pct  = $urandom_range(0, 120);
        case (sel)
            0: begin
                thr = 0; tol = 0; solo = 1; step = 1; frac = 65536; pct = 1000;
            end
            1: begin
                thr = 65535; tol = 32767; solo = 65535; step = 65535; frac = 0; pct = 0;
            end
            2: begin
                solo = 0; step = 0; pct = $urandom_range(0, 30);
            end
            default: ;
        endcase
        write_reg(REG_DEPTH_THR, thr);
        write_reg(REG_RPM_FLOOR, tol);
        write_reg(REG_SOLO, solo);
        write_reg(REG_STEP, step);
        write_reg(REG_STEP_FRAC, frac);
        write_reg(REG_MAX_PCT, pct);
    endtask

    // Wait for all ticks to go in and every result to come out, then let the pipe settle
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || in_if.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                in_if.item  <= pending_ticks.pop_front();
                in_if.valid <= 1'b1;
                if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                    gap_left = $urandom_range(1, 5);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                stall_left = $urandom_range(1, 5);
        end
    end

    // Predict on every accepted tick
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            due_results.push_back(supervise_tick(in_if.item));
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none got %h",
                         $time, out_if.item);
            end else begin
                want = due_results.pop_front();
                check_field("phase", want.phase, out_if.item.phase);
                check_field("speed_cmd", want.speed_cmd, out_if.item.speed_cmd);
                check_field("speed_cmd_valid", want.speed_cmd_valid,
                            out_if.item.speed_cmd_valid);
                check_field("restore_refs", want.restore_refs, out_if.item.restore_refs);
                check_field("failed", want.failed, out_if.item.failed);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int ph;
        int n;
        int len;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.item   = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        mismatches   = 0;
        cycle_cnt    = 0;
        gap_left     = 0;
        stall_left   = 0;
        gap_odds     = 4;
        stall_odds   = 4;
        cfg_model    = '{RST_DEPTH_THR, RST_RPM_FLOOR, RST_SOLO, RST_STEP,
                         RST_STEP_FRAC, RST_MAX_PCT};
        sv_en_prev   = 1'b0;
        sv_failed    = 1'b0;
        sv_forced    = 0;
        clear_machine();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at the reset settings
        add_tick(0, 0, 1000, 1000, 500, 1000, 1000, ZM_DEPTH);              // disabled
        add_tick(1, 0, -8388608, -8388608, -32768, -8388608, -8388608, ZM_NONE);
        add_tick(1, 1, 8388607, 8388607, 32767, 8388607, 8388607, ZM_BAD); // brake, idle
        add_tick(1, 0, 100, 0, 500, -5, 5000, ZM_DEPTH);                    // speed missing
        add_tick(1, 0, 0, 0, 32767, 8388607, 8388607, ZM_DEPTH);            // data in, check
        repeat (3) add_tick(1, 0, 100, 0, 300, 8388607, 8388607, ZM_DEPTH);
        add_tick(1, 0, 601, 0, 300, 8388607, 8388607, ZM_DEPTH);            // submerged
        add_tick(1, 0, 299, 0, 300, 8388607, 8388607, ZM_DEPTH);            // hysteresis
        add_tick(1, 1, 100, 0, 300, 8388607, 8388607, ZM_DEPTH);            // brake in check
        add_tick(1, 0, 0, 0, 300, 8388607, 8388607, ZM_DEPTH);
        repeat (8) add_tick(1, 0, 100, 0, 300, 8388607, 8388607, ZM_DEPTH); // into forcing
        add_tick(1, 0, 601, 0, 300, 8388607, 8388607, ZM_DEPTH);            // reached depth
        add_tick(1, 0, 5000, 1000, 300, 100, 900, ZM_ALT);                  // too close to bottom
        add_tick(0, 0, 0, 0, 0, 0, 0, ZM_NONE);                             // enable fall
        wait_drained();

        // Random dives under several settings, the last one without idling
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) begin
                gap_odds = 0;
                stall_odds = 0;
            end else begin
                gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
            end
            load_setting(ph);
            n = 0;
            while (n < ((ph == 1) ? 40 : 80)) begin
                queue_segment(len);
                n += len;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
